### hdl/bounded_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Bounded priority queue assertion macros
// Shared helpers for the concurrent checks on the queue ports.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Sizes, command and status codes, controller types.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // Storage depth and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command codes
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_NOP = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed
    {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

### hdl/bounded_priority_queue.sv
// ----------------------------------------------------------------------------
// Bounded priority queue
// Sorted queue of value and priority pairs, highest priority at the head.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command word: s_tuser selects enqueue, dequeue
//   or status only; s_tdata holds the value and priority for an enqueue.
//   Master stream returns exactly one result word per command: s_tuser-style
//   status on m_tuser and head value, head priority, count and flags on
//   m_tdata, all as they stand after the command.
//   cfg channel writes the capacity (5 bits); write it only while idle.
//   Each word is captured in ST_IDLE, then compared in ST_EXEC against all
//   held entries at once to shift the array and load the result register.
//   A new word is accepted only once ST_EXEC is done, not while it runs.
//   A finished result waits in the output register while the next word is
//   accepted; that word's execution holds until the result is taken.
//   Reset empties the queue, sets capacity to 16 and clears m_tvalid.
//   A stalled receiver holds m_tvalid and the result word unchanged.
// ----------------------------------------------------------------------------
module bounded_priority_queue
    import bpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [31:0] item_value, [63:32] item_priority
    input  logic [1:0]       s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // [31:0] head_value, [63:32] head_priority,
                                        // [68:64] entry_count, [69] is_empty,
                                        // [70] is_full, [71] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data   // capacity
);

    ctrl_cmd_t                cmd;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] head_priority;
    logic [CAP_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic [1:0]               status;

    // Capacity writes are always taken
    assign cfg_ready = 1'b1;

    bpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bpq_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_cmd        (s_tuser),
        .in_value      (s_tdata[31:0]),
        .in_priority   (s_tdata[63:32]),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .status        (status),
        .head_value    (head_value),
        .head_priority (head_priority),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    // Pack the result word
    assign m_tdata = {1'b0, is_full, is_empty, entry_count, head_priority, head_value};
    assign m_tuser = status;

endmodule

### hdl/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded priority queue controller
// Sequences capture and execution of one word and owns the output valid.
// ----------------------------------------------------------------------------
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Output slot can take a new result
    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.execute = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Set valid on a new result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/bpq_datapath.sv
// ----------------------------------------------------------------------------
// Bounded priority queue datapath
// Shift-insert entry array with per-slot compare, capacity and result register.
// ----------------------------------------------------------------------------
module bpq_datapath
    import bpq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic [1:0]               in_cmd,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic signed [DATA_W-1:0] in_priority,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_data,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] head_priority,
    output logic [CAP_W-1:0]         entry_count,
    output logic                     is_empty,
    output logic                     is_full
);

    // Captured word
    logic [1:0]               cmd_reg;
    logic signed [DATA_W-1:0] val_in_reg;
    logic signed [DATA_W-1:0] pri_in_reg;

    // Entry array, slot 0 is the head
    logic signed [DATA_W-1:0] val_reg  [DEPTH];
    logic signed [DATA_W-1:0] pri_reg  [DEPTH];
    logic signed [DATA_W-1:0] val_next [DEPTH];
    logic signed [DATA_W-1:0] pri_next [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CAP_W-1:0]         cap_reg;

    // Result register
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] head_val_reg;
    logic signed [DATA_W-1:0] head_pri_reg;
    logic [CAP_W-1:0]         count_out_reg;
    logic                     empty_reg;
    logic                     full_reg;

    logic [DEPTH-1:0]         ge;
    logic [CMP_W-1:0]         eff_cap;
    logic                     full_now;
    logic                     full_after;
    logic                     do_enq;
    logic                     do_deq;
    logic [1:0]               status_next;

    // Limit capacity to the array depth
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign full_now   = CMP_W'(count_reg) >= eff_cap;
    assign full_after = CMP_W'(count_next) >= eff_cap;

    // Per-slot compare: held entry stays ahead of the new one
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ge[k] = (CNT_W'(k) < count_reg) && (pri_reg[k] >= pri_in_reg);
        end
    end

    assign do_enq = cmd.execute && (cmd_reg == CMD_ENQ) && !full_now;
    assign do_deq = cmd.execute && (cmd_reg == CMD_DEQ) && (count_reg != '0);

    // Next array contents: insert behind the prefix, or shift toward the head
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            val_next[k] = val_reg[k];
            pri_next[k] = pri_reg[k];
            if (do_enq && !ge[k])
            begin
                if (k == 0)
                begin
                    val_next[k] = val_in_reg;
                    pri_next[k] = pri_in_reg;
                end
                else if (ge[k-1])
                begin
                    val_next[k] = val_in_reg;
                    pri_next[k] = pri_in_reg;
                end
                else
                begin
                    val_next[k] = val_reg[k-1];
                    pri_next[k] = pri_reg[k-1];
                end
            end
            else if (do_deq && (k < DEPTH - 1))
            begin
                val_next[k] = val_reg[k+1];
                pri_next[k] = pri_reg[k+1];
            end
        end
    end

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Result status
    always_comb
    begin
        status_next = STAT_OK;
        case (cmd_reg)
            CMD_ENQ:
            begin
                if (full_now)
                begin
                    status_next = STAT_FULL;
                end
            end
            CMD_DEQ:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= in_cmd;
            val_in_reg <= in_value;
            pri_in_reg <= in_priority;
        end
    end

    // Advance the entry array
    always_ff @(posedge clk)
    begin
        if (do_enq || do_deq)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                val_reg[k] <= val_next[k];
                pri_reg[k] <= pri_next[k];
            end
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            head_val_reg  <= (count_next != '0) ? val_next[0] : '0;
            head_pri_reg  <= (count_next != '0) ? pri_next[0] : '0;
            count_out_reg <= CAP_W'(count_next);
            empty_reg     <= (count_next == '0);
            full_reg      <= full_after;
        end
    end

    // Count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign status        = status_reg;
    assign head_value    = head_val_reg;
    assign head_priority = head_pri_reg;
    assign entry_count   = count_out_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule

### hdl/bpq_checker.sv
// ----------------------------------------------------------------------------
// Bounded priority queue checker
// Port-level checks on ordering of handshakes and result consistency.
// ----------------------------------------------------------------------------
`include "bounded_priority_queue_defines.svh"

module bpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic        res_empty;
    logic [4:0]  res_count;
    logic [63:0] res_head;

    // Split the result word
    assign res_empty = m_tdata[69];
    assign res_count = m_tdata[68:64];
    assign res_head  = m_tdata[63:0];

    // A stalled result stays offered
    `BPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // One word in flight: no accept right after an accept
    `BPQ_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "word accepted while busy")

    // Empty flag matches the count
    `BPQ_ASSERT_NOW(a_empty_cnt, m_tvalid, res_empty == (res_count == 5'd0), "bad empty flag")

    // Empty queue reports a zero head
    `BPQ_ASSERT_NOW(a_empty_head, m_tvalid && res_empty, res_head == 64'd0, "head not zero")

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (.*);
